@@ rtl/ngga_pkg.sv @@
// shared types, constants and a helper function for the GGA sentence parser
// no dependencies; used by every module of the block through scoped names
package ngga_pkg;

	localparam int MAX_LINE    = 128;
	localparam int FRAC_DIGITS = 5;

	localparam int LEN_W  = $clog2(MAX_LINE);
	localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
	localparam int CNT_W  = $clog2(FRAC_DIGITS + 1);
	localparam int FLD_W  = 5;
	localparam int IP_W   = 15;

	// characters
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	// comma field numbers
	localparam logic [FLD_W-1:0] FLD_LAT      = 5'd2;
	localparam logic [FLD_W-1:0] FLD_LAT_HEMI = 5'd3;
	localparam logic [FLD_W-1:0] FLD_LON      = 5'd4;
	localparam logic [FLD_W-1:0] FLD_LON_HEMI = 5'd5;
	localparam logic [FLD_W-1:0] FLD_FIX      = 5'd6;
	localparam logic [FLD_W-1:0] FLD_SAT      = 5'd7;
	localparam logic [FLD_W-1:0] FLD_HDOP     = 5'd8;
	localparam logic [FLD_W-1:0] FLD_MIN_CNT  = 5'd9;
	localparam logic [FLD_W-1:0] FLD_MAX      = 5'd31;

	localparam int HDR_LEN = 6;

	// coordinate conversion
	localparam int COORD_SAT    = 1800000000;
	localparam int DEG_UNIT     = 10000000;
	localparam int IP_SAT_LIMIT = 18100;
	// floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT for x < 2**15
	localparam logic [14:0] DIV100_MUL   = 15'd20972;
	localparam int          DIV100_SHIFT = 21;
	// floor(x / 60) = (x * DIV60_MUL) >> DIV60_SHIFT for x < 1e9
	localparam logic [30:0] DIV60_MUL    = 31'd1145324613;
	localparam int          DIV60_SHIFT  = 36;

	localparam logic [23:0] POW10 [8] = '{
		24'd1, 24'd10, 24'd100, 24'd1000,
		24'd10000, 24'd100000, 24'd1000000, 24'd10000000
	};

	typedef enum logic [3:0] {
		PH_LEAD = 4'b0001,
		PH_INT  = 4'b0010,
		PH_FRAC = 4'b0100,
		PH_DONE = 4'b1000
	} scan_phase_t;

	typedef struct packed {
		logic              zero;
		logic              neg;
		logic              big;
		logic [IP_W-1:0]   ip;
		logic [FRAC_W-1:0] frac;
		logic [CNT_W-1:0]  cnt;
	} coord_snap_t;

	typedef struct packed {
		logic        ok;
		logic        fix_valid;
		logic [7:0]  sat;
		logic [15:0] hdop;
	} side_t;

	typedef struct packed {
		side_t                  side;
		coord_snap_t [1:0]      coord;
	} line_snap_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} pipe_ld_t;

	// 10**(7-cnt): lifts a fraction with cnt digits to seven digits
	function automatic logic [23:0] frac_scale(input logic [CNT_W-1:0] cnt);
		logic [3:0] idx;
		idx = 4'd7 - 4'(cnt);
		return POW10[idx[2:0]];
	endfunction

endpackage

@@ rtl/ngga_line_scan.sv @@
// per-word line state of the GGA parser: header check, field count, number scan
// depends on ngga_pkg; produces the line snapshot when a line ends
module ngga_line_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          rx_byte,
	output logic                emit,
	output ngga_pkg::line_snap_t snap
);

	logic [ngga_pkg::LEN_W-1:0]  len_q;
	logic [ngga_pkg::FLD_W-1:0]  fld_q;
	logic                        hdr_q;
	logic                        star_q;
	logic [31:0]                 ci_q  [2];
	logic [ngga_pkg::FRAC_W-1:0] cf_q  [2];
	logic [ngga_pkg::CNT_W-1:0]  cc_q  [2];
	logic [2:0]                  cfl_q [2];
	logic [15:0]                 fix_q;
	logic [7:0]                  sat_q;
	logic [15:0]                 hdop_q;
	ngga_pkg::scan_phase_t       phase_q;
	logic [2:0]                  sgn_q;
	logic [1:0]                  hfr_q;

	logic [ngga_pkg::LEN_W-1:0]  n_len;
	logic [ngga_pkg::FLD_W-1:0]  n_fld;
	logic                        n_hdr;
	logic                        n_star;
	logic [31:0]                 n_ci  [2];
	logic [ngga_pkg::FRAC_W-1:0] n_cf  [2];
	logic [ngga_pkg::CNT_W-1:0]  n_cc  [2];
	logic [2:0]                  n_cfl [2];
	logic [15:0]                 n_fix;
	logic [7:0]                  n_sat;
	logic [15:0]                 n_hdop;
	ngga_pkg::scan_phase_t       n_phase;
	logic [2:0]                  n_sgn;
	logic [1:0]                  n_hfr;
	logic                        clr;

	logic                        c_idx;
	logic                        is_digit;
	logic                        is_ws;
	logic                        has_frac;
	logic                        in_frac;
	logic [3:0]                  dig;
	logic                        hdr_ch_ok;
	logic [35:0]                 ci_v;
	logic [19:0]                 fix_v;
	logic [20:0]                 hdop_v;
	logic                        ok;

	assign c_idx    = (fld_q == ngga_pkg::FLD_LON) || (fld_q == ngga_pkg::FLD_LON_HEMI);
	assign is_digit = (rx_byte >= ngga_pkg::CH_ZERO) && (rx_byte <= ngga_pkg::CH_NINE);
	assign is_ws    = (rx_byte == ngga_pkg::CH_SPACE) || (rx_byte == ngga_pkg::CH_TAB) ||
	                  (rx_byte == ngga_pkg::CH_VT) || (rx_byte == ngga_pkg::CH_FF);
	assign has_frac = (fld_q == ngga_pkg::FLD_LAT) || (fld_q == ngga_pkg::FLD_LON) ||
	                  (fld_q == ngga_pkg::FLD_HDOP);
	assign in_frac  = (phase_q == ngga_pkg::PH_FRAC);
	assign dig      = 4'(rx_byte - ngga_pkg::CH_ZERO);

	always_comb begin
		unique case (len_q)
			ngga_pkg::LEN_W'(0): hdr_ch_ok = (rx_byte == ngga_pkg::CH_DOLLAR);
			ngga_pkg::LEN_W'(2): hdr_ch_ok = (rx_byte == ngga_pkg::CH_P) ||
			                                 (rx_byte == ngga_pkg::CH_N);
			ngga_pkg::LEN_W'(1),
			ngga_pkg::LEN_W'(3),
			ngga_pkg::LEN_W'(4): hdr_ch_ok = (rx_byte == ngga_pkg::CH_G);
			ngga_pkg::LEN_W'(5): hdr_ch_ok = (rx_byte == ngga_pkg::CH_A);
			default:             hdr_ch_ok = 1'b1;
		endcase
	end

	always_comb begin
		n_len   = len_q;
		n_fld   = fld_q;
		n_hdr   = hdr_q;
		n_star  = star_q;
		n_ci    = ci_q;
		n_cf    = cf_q;
		n_cc    = cc_q;
		n_cfl   = cfl_q;
		n_fix   = fix_q;
		n_sat   = sat_q;
		n_hdop  = hdop_q;
		n_phase = phase_q;
		n_sgn   = sgn_q;
		n_hfr   = hfr_q;
		emit    = 1'b0;
		clr     = 1'b0;
		ci_v    = {4'd0, ci_q[c_idx]} * 36'd10 + 36'(dig);
		fix_v   = 20'(fix_q) * 20'd10 + 20'(dig);
		if (!in_frac) begin
			hdop_v = 21'(hdop_q) * 21'd10 + 21'(dig) * 21'd100;
		end else if (hfr_q == 2'd0) begin
			hdop_v = 21'(hdop_q) + 21'(dig) * 21'd10;
		end else begin
			hdop_v = 21'(hdop_q) + 21'(dig);
		end

		if (rx_byte == ngga_pkg::CH_CR) begin
			n_len = len_q;
		end else if (rx_byte == ngga_pkg::CH_LF) begin
			if (len_q != '0) begin
				emit = 1'b1;
				clr  = 1'b1;
			end
		end else begin
			if (len_q < ngga_pkg::LEN_W'(ngga_pkg::HDR_LEN) && !hdr_ch_ok) begin
				n_hdr = 1'b0;
			end
			if (!star_q) begin
				if (rx_byte == ngga_pkg::CH_STAR) begin
					n_star = 1'b1;
				end else if (rx_byte == ngga_pkg::CH_COMMA) begin
					if (fld_q < ngga_pkg::FLD_MAX) begin
						n_fld = fld_q + 1'b1;
					end
					n_phase = ngga_pkg::PH_LEAD;
				end else if (fld_q == ngga_pkg::FLD_LAT_HEMI ||
				             fld_q == ngga_pkg::FLD_LON_HEMI) begin
					// only the first character of a hemisphere field counts
					if (phase_q == ngga_pkg::PH_LEAD) begin
						n_cfl[c_idx][1] = 1'b1;
						if (rx_byte == ngga_pkg::CH_S || rx_byte == ngga_pkg::CH_W) begin
							n_cfl[c_idx][2] = 1'b1;
						end
						n_phase = ngga_pkg::PH_DONE;
					end
				end else if (fld_q >= ngga_pkg::FLD_LAT && fld_q <= ngga_pkg::FLD_HDOP &&
				             phase_q != ngga_pkg::PH_DONE) begin
					if (phase_q == ngga_pkg::PH_LEAD && is_ws) begin
						n_phase = phase_q;
					end else if (phase_q == ngga_pkg::PH_LEAD &&
					             (rx_byte == ngga_pkg::CH_PLUS ||
					              rx_byte == ngga_pkg::CH_MINUS)) begin
						n_phase = ngga_pkg::PH_INT;
						if (rx_byte == ngga_pkg::CH_MINUS) begin
							if (fld_q == ngga_pkg::FLD_LAT || fld_q == ngga_pkg::FLD_LON) begin
								n_cfl[c_idx][0] = 1'b1;
							end else if (fld_q == ngga_pkg::FLD_FIX) begin
								n_sgn[0] = 1'b1;
							end else if (fld_q == ngga_pkg::FLD_SAT) begin
								n_sgn[1] = 1'b1;
							end else begin
								n_sgn[2] = 1'b1;
							end
						end
					end else if (is_digit) begin
						if (!in_frac) begin
							n_phase = ngga_pkg::PH_INT;
						end
						if (fld_q == ngga_pkg::FLD_LAT || fld_q == ngga_pkg::FLD_LON) begin
							if (in_frac) begin
								if (cc_q[c_idx] < ngga_pkg::CNT_W'(ngga_pkg::FRAC_DIGITS)) begin
									n_cf[c_idx] = ngga_pkg::FRAC_W'(cf_q[c_idx] *
									              ngga_pkg::FRAC_W'(10) +
									              ngga_pkg::FRAC_W'(dig));
									n_cc[c_idx] = cc_q[c_idx] + 1'b1;
								end
							end else begin
								n_ci[c_idx] = (ci_v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : ci_v[31:0];
							end
						end else if (fld_q == ngga_pkg::FLD_FIX) begin
							n_fix = (fix_v > 20'hFFFF) ? 16'hFFFF : fix_v[15:0];
						end else if (fld_q == ngga_pkg::FLD_SAT) begin
							n_sat = 8'(sat_q * 8'd10 + 8'(dig));
						end else if (!in_frac || hfr_q < 2'd2) begin
							// hdop keeps two fraction digits only
							n_hdop = (hdop_v > 21'hFFFF) ? 16'hFFFF : hdop_v[15:0];
							if (in_frac) begin
								n_hfr = hfr_q + 1'b1;
							end
						end
					end else if (rx_byte == ngga_pkg::CH_DOT && has_frac && !in_frac) begin
						n_phase = ngga_pkg::PH_FRAC;
					end else begin
						n_phase = ngga_pkg::PH_DONE;
					end
				end
			end
			n_len = len_q + 1'b1;
			if (n_len == ngga_pkg::LEN_W'(ngga_pkg::MAX_LINE - 1)) begin
				emit = 1'b1;
				clr  = 1'b1;
			end
		end
	end

	// snapshot of the line as it stands after this word
	always_comb begin
		ok                  = n_hdr && (n_len >= ngga_pkg::LEN_W'(ngga_pkg::HDR_LEN)) &&
		                      (n_fld >= ngga_pkg::FLD_MIN_CNT);
		snap.side.ok        = ok;
		snap.side.fix_valid = ok && !n_sgn[0] && (n_fix != '0);
		snap.side.sat       = !ok ? 8'd0 : (n_sgn[1] ? 8'(-n_sat) : n_sat);
		snap.side.hdop      = (ok && !n_sgn[2]) ? n_hdop : 16'd0;
		for (int i = 0; i < 2; i++) begin
			snap.coord[i].zero = !ok || !n_cfl[i][1] || n_cfl[i][0] ||
			                     (n_ci[i] == '0 && n_cf[i] == '0);
			snap.coord[i].neg  = n_cfl[i][2];
			snap.coord[i].big  = n_ci[i] >= 32'(ngga_pkg::IP_SAT_LIMIT);
			snap.coord[i].ip   = n_ci[i][ngga_pkg::IP_W-1:0];
			snap.coord[i].frac = n_cf[i];
			snap.coord[i].cnt  = n_cc[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			fld_q   <= '0;
			hdr_q   <= 1'b1;
			star_q  <= 1'b0;
			ci_q    <= '{default: '0};
			cf_q    <= '{default: '0};
			cc_q    <= '{default: '0};
			cfl_q   <= '{default: '0};
			fix_q   <= '0;
			sat_q   <= '0;
			hdop_q  <= '0;
			phase_q <= ngga_pkg::PH_LEAD;
			sgn_q   <= '0;
			hfr_q   <= '0;
		end else if (take) begin
			if (clr) begin
				len_q   <= '0;
				fld_q   <= '0;
				hdr_q   <= 1'b1;
				star_q  <= 1'b0;
				ci_q    <= '{default: '0};
				cf_q    <= '{default: '0};
				cc_q    <= '{default: '0};
				cfl_q   <= '{default: '0};
				fix_q   <= '0;
				sat_q   <= '0;
				hdop_q  <= '0;
				phase_q <= ngga_pkg::PH_LEAD;
				sgn_q   <= '0;
				hfr_q   <= '0;
			end else begin
				len_q   <= n_len;
				fld_q   <= n_fld;
				hdr_q   <= n_hdr;
				star_q  <= n_star;
				ci_q    <= n_ci;
				cf_q    <= n_cf;
				cc_q    <= n_cc;
				cfl_q   <= n_cfl;
				fix_q   <= n_fix;
				sat_q   <= n_sat;
				hdop_q  <= n_hdop;
				phase_q <= n_phase;
				sgn_q   <= n_sgn;
				hfr_q   <= n_hfr;
			end
		end
	end

	a_len_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		len_q < ngga_pkg::LEN_W'(ngga_pkg::MAX_LINE - 1))
		else $error("line length reached the forced line end without clearing");

	a_hdop_frac_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		hfr_q <= 2'd2)
		else $error("hdop fraction digit count beyond two");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		take && emit |=> (len_q == '0) && (fld_q == '0) && hdr_q && !star_q)
		else $error("line state not cleared after a line end");

endmodule

@@ rtl/ngga_coord_conv.sv @@
// pipelined conversion of one ddmm.mmmmm coordinate to 1e-7 degree units
// depends on ngga_pkg; stage loads come from ngga_result_pipe
module ngga_coord_conv (
	input  logic                  clk,
	input  ngga_pkg::pipe_ld_t    ld,
	input  ngga_pkg::coord_snap_t snap,
	output logic signed [31:0]    value
);

	ngga_pkg::coord_snap_t snap_s1;

	logic                       zero_s2, neg_s2, big_s2;
	logic [ngga_pkg::IP_W-1:0]  ip_s2;
	logic [7:0]                 q_s2;
	logic [23:0]                fsc_s2;

	logic                       zero_s3, neg_s3, big_s3;
	logic [6:0]                 r_s3;
	logic [30:0]                deg_s3;
	logic [23:0]                fsc_s3;

	logic                       zero_s4, neg_s4, big_s4;
	logic [29:0]                t_s4;
	logic [30:0]                deg_s4;

	logic                       zero_s5, neg_s5, big_s5;
	logic [23:0]                m_s5;
	logic [30:0]                deg_s5;

	logic [29:0]                q_prod;
	logic [ngga_pkg::FRAC_W+23:0] fsc_prod;
	logic [60:0]                m_prod;
	logic [31:0]                mag;
	logic [31:0]                mag_sat;

	// quotient by 100 only matters below the saturation limit
	assign q_prod   = 30'(snap_s1.ip) * 30'(ngga_pkg::DIV100_MUL);
	assign fsc_prod = (ngga_pkg::FRAC_W + 24)'(snap_s1.frac) *
	                  (ngga_pkg::FRAC_W + 24)'(ngga_pkg::frac_scale(snap_s1.cnt));
	assign m_prod   = 61'(t_s4) * 61'(ngga_pkg::DIV60_MUL);
	assign mag      = 32'(deg_s5) + 32'(m_s5);
	assign mag_sat  = (big_s5 || mag > 32'(ngga_pkg::COORD_SAT)) ?
	                  32'(ngga_pkg::COORD_SAT) : mag;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			snap_s1 <= snap;
		end
		if (ld.s2) begin
			zero_s2 <= snap_s1.zero;
			neg_s2  <= snap_s1.neg;
			big_s2  <= snap_s1.big;
			ip_s2   <= snap_s1.ip;
			q_s2    <= q_prod[ngga_pkg::DIV100_SHIFT +: 8];
			fsc_s2  <= fsc_prod[23:0];
		end
		if (ld.s3) begin
			zero_s3 <= zero_s2;
			neg_s3  <= neg_s2;
			big_s3  <= big_s2;
			r_s3    <= 7'(ip_s2 - 15'(q_s2) * 15'd100);
			deg_s3  <= 31'(q_s2) * 31'(ngga_pkg::DEG_UNIT);
			fsc_s3  <= fsc_s2;
		end
		if (ld.s4) begin
			zero_s4 <= zero_s3;
			neg_s4  <= neg_s3;
			big_s4  <= big_s3;
			// minutes scaled to seven fraction digits
			t_s4    <= 30'(r_s3) * 30'(ngga_pkg::DEG_UNIT) + 30'(fsc_s3);
			deg_s4  <= deg_s3;
		end
		if (ld.s5) begin
			zero_s5 <= zero_s4;
			neg_s5  <= neg_s4;
			big_s5  <= big_s4;
			m_s5    <= m_prod[ngga_pkg::DIV60_SHIFT +: 24];
			deg_s5  <= deg_s4;
		end
		if (ld.s6) begin
			value <= zero_s5 ? 32'sd0 : (neg_s5 ? -$signed(mag_sat) : $signed(mag_sat));
		end
	end

endmodule

@@ rtl/ngga_result_pipe.sv @@
// six-stage result pipeline with per-stage valid and ready, output register last
// depends on ngga_pkg and ngga_coord_conv
module ngga_result_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ngga_pkg::line_snap_t snap,
	output logic                 ready,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 parse_ok,
	output logic                 fix_valid,
	output logic signed [31:0]   latitude,
	output logic signed [31:0]   longitude,
	output logic [7:0]           satellites,
	output logic [15:0]          hdop_centi
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	ngga_pkg::pipe_ld_t ld;
	ngga_pkg::side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;

	// a stage takes a word when it is empty or its word moves on
	assign rdy_s6 = !v_s6 || !res_stall;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign ready  = rdy_s1;

	assign ld = '{s1: rdy_s1, s2: rdy_s2, s3: rdy_s3, s4: rdy_s4, s5: rdy_s5, s6: rdy_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= push;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) side_s1 <= snap.side;
		if (rdy_s2) side_s2 <= side_s1;
		if (rdy_s3) side_s3 <= side_s2;
		if (rdy_s4) side_s4 <= side_s3;
		if (rdy_s5) side_s5 <= side_s4;
		if (rdy_s6) side_s6 <= side_s5;
	end

	ngga_coord_conv u_lat (
		.clk   (clk),
		.ld    (ld),
		.snap  (snap.coord[0]),
		.value (latitude)
	);

	ngga_coord_conv u_lon (
		.clk   (clk),
		.ld    (ld),
		.snap  (snap.coord[1]),
		.value (longitude)
	);

	assign res_valid  = v_s6;
	assign parse_ok   = side_s6.ok;
	assign fix_valid  = side_s6.fix_valid;
	assign satellites = side_s6.sat;
	assign hdop_centi = side_s6.hdop;

	a_full_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!ready |-> v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && res_stall)
		else $error("line scan held off while the pipeline has a free stage");

	a_fail_all_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !parse_ok |-> !fix_valid && latitude == 32'sd0 &&
		longitude == 32'sd0 && satellites == 8'd0 && hdop_centi == 16'd0)
		else $error("failed line carries nonzero fields");

	a_coord_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> latitude <= ngga_pkg::COORD_SAT && latitude >= -ngga_pkg::COORD_SAT &&
		longitude <= ngga_pkg::COORD_SAT && longitude >= -ngga_pkg::COORD_SAT)
		else $error("coordinate outside its saturation range");

endmodule

@@ rtl/nmea_gga_sentence_parser_core.sv @@
// GGA sentence parser: one received character per word in, one result per line end out
// a result passes through the six result stages, s1 to s6, once the word ending its line
// is taken; one word per cycle is taken while rx_stall is low
// rx_stall rises only when all six result stages hold a word and res_stall is high
// arst_n clears the line state and every stage valid; the first line starts right after
module nmea_gga_sentence_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  logic [7:0]         rx_byte,
	output logic               res_valid,
	input  logic               res_stall,
	output logic               parse_ok,
	output logic               fix_valid,
	output logic signed [31:0] latitude,
	output logic signed [31:0] longitude,
	output logic [7:0]         satellites,
	output logic [15:0]        hdop_centi
);

	logic                 take;
	logic                 emit;
	logic                 pipe_ready;
	ngga_pkg::line_snap_t snap;

	assign rx_stall = !pipe_ready;
	assign take     = rx_valid && pipe_ready;

	ngga_line_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.emit    (emit),
		.snap    (snap)
	);

	ngga_result_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (take && emit),
		.snap       (snap),
		.ready      (pipe_ready),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.parse_ok   (parse_ok),
		.fix_valid  (fix_valid),
		.latitude   (latitude),
		.longitude  (longitude),
		.satellites (satellites),
		.hdop_centi (hdop_centi)
	);

endmodule

@@ tb/nmea_gga_sentence_parser_core_tb.sv @@
// testbench for the GGA sentence parser core: streams characters, predicts line results
// depends on ngga_pkg for character codes, field numbers and limits
`timescale 1ns / 100ps

module nmea_gga_sentence_parser_core_tb;
	import ngga_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 600;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic               ok;
		logic               fix;
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic [7:0]         sat;
		logic [15:0]        hdop;
	} gga_fix_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               rx_valid = 1'b0;
	logic               rx_stall;
	logic [7:0]         rx_byte = 8'h00;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic               parse_ok;
	logic               fix_valid;
	logic signed [31:0] latitude;
	logic signed [31:0] longitude;
	logic [7:0]         satellites;
	logic [15:0]        hdop_centi;

	nmea_gga_sentence_parser_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.parse_ok   (parse_ok),
		.fix_valid  (fix_valid),
		.latitude   (latitude),
		.longitude  (longitude),
		.satellites (satellites),
		.hdop_centi (hdop_centi)
	);

	always #1 clk = ~clk;

	// characters waiting to be sent and line results still owed by the block
	logic [7:0] char_q [$];
	gga_fix_t   fix_report_q [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int err_cnt = 0;
	int chars_queued = 0;
	int chars_taken = 0;
	int lines_queued = 0;
	int reports_checked = 0;
	int stalled_cycles = 0;
	int cycle_cnt = 0;
	int hold_left = 0;
	logic hold_go = 1'b0;

	// line tracker state
	int          lin_len;
	int          fld_num;
	bit          hdr_good;
	bit          star_seen;
	logic [31:0] c_int [2];
	int unsigned c_frac [2];
	int          c_cnt [2];
	logic [2:0]  c_flags [2];	// minus sign, hemisphere seen, south or west
	int          fix_acc;
	int          sat_acc;
	int          hdop_acc;
	int          hdop_fd;
	logic [2:0]  sgn;	// minus on fix, satellites, hdop
	scan_phase_t phase;

	task automatic gga_clear();
		lin_len = 0;
		fld_num = 0;
		hdr_good = 1'b1;
		star_seen = 1'b0;
		for (int c = 0; c < 2; c++) begin
			c_int[c] = '0;
			c_frac[c] = 0;
			c_cnt[c] = 0;
			c_flags[c] = '0;
		end
		fix_acc = 0;
		sat_acc = 0;
		hdop_acc = 0;
		hdop_fd = 0;
		sgn = '0;
		phase = PH_LEAD;
	endtask

	function automatic logic signed [31:0] coord_deg7(int c);
		longint unsigned ip, sc, mins, mag;
		ip = c_int[c];
		sc = 1;
		repeat (c_cnt[c]) sc = sc * 10;
		if (!c_flags[c][1] || c_flags[c][0])
			return '0;
		if (ip == 0 && c_frac[c] == 0)
			return '0;
		mins = (ip % 100) * sc + c_frac[c];
		mag = (ip / 100) * DEG_UNIT + (mins * DEG_UNIT) / (60 * sc);
		if (mag > COORD_SAT)
			mag = COORD_SAT;
		return c_flags[c][2] ? -$signed(mag[31:0]) : $signed(mag[31:0]);
	endfunction

	task automatic gga_close_line();
		gga_fix_t r;
		r = '0;
		if (hdr_good && lin_len >= HDR_LEN && fld_num >= FLD_MIN_CNT) begin
			r.ok = 1'b1;
			r.fix = !sgn[0] && fix_acc > 0;
			r.lat = coord_deg7(0);
			r.lon = coord_deg7(1);
			r.sat = sgn[1] ? 8'(0 - sat_acc) : 8'(sat_acc);
			r.hdop = sgn[2] ? 16'd0 : 16'(hdop_acc);
		end
		fix_report_q.push_back(r);
		gga_clear();
	endtask

	task automatic gga_take_digit(int f, int d, bit in_frac);
		int c;
		longint unsigned v;
		if (f == FLD_LAT || f == FLD_LON) begin
			c = (f == FLD_LAT) ? 0 : 1;
			if (in_frac) begin
				if (c_cnt[c] < FRAC_DIGITS) begin
					c_frac[c] = c_frac[c] * 10 + d;
					c_cnt[c]++;
				end
			end else begin
				v = c_int[c];
				v = v * 10 + d;
				c_int[c] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			end
		end else if (f == FLD_FIX) begin
			v = fix_acc * 10 + d;
			fix_acc = (v > 65535) ? 65535 : int'(v);
		end else if (f == FLD_SAT) begin
			sat_acc = (sat_acc * 10 + d) & 255;
		end else if (f == FLD_HDOP) begin
			if (in_frac) begin
				if (hdop_fd < 2) begin
					v = hdop_acc + d * ((hdop_fd == 0) ? 10 : 1);
					hdop_fd++;
					hdop_acc = (v > 65535) ? 65535 : int'(v);
				end
			end else begin
				v = hdop_acc * 10 + d * 100;
				hdop_acc = (v > 65535) ? 65535 : int'(v);
			end
		end
	endtask

	task automatic gga_scan(logic [7:0] ch);
		int f;
		int c;
		bit frac_field;
		f = fld_num;
		frac_field = (f == FLD_LAT || f == FLD_LON || f == FLD_HDOP);
		if (f == FLD_LAT_HEMI || f == FLD_LON_HEMI) begin
			// only the first character of a hemisphere field counts
			if (phase == PH_LEAD) begin
				c = (f == FLD_LAT_HEMI) ? 0 : 1;
				c_flags[c][1] = 1'b1;
				if (ch == CH_S || ch == CH_W)
					c_flags[c][2] = 1'b1;
				phase = PH_DONE;
			end
			return;
		end
		if (f < FLD_LAT || f > FLD_HDOP || phase == PH_DONE)
			return;
		if (phase == PH_LEAD && (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF))
			return;
		if (phase == PH_LEAD && (ch == CH_PLUS || ch == CH_MINUS)) begin
			phase = PH_INT;
			if (ch == CH_MINUS) begin
				case (f)
					FLD_LAT: c_flags[0][0] = 1'b1;
					FLD_LON: c_flags[1][0] = 1'b1;
					FLD_FIX: sgn[0] = 1'b1;
					FLD_SAT: sgn[1] = 1'b1;
					default: sgn[2] = 1'b1;
				endcase
			end
			return;
		end
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			if (phase == PH_FRAC) begin
				gga_take_digit(f, ch - CH_ZERO, 1'b1);
			end else begin
				phase = PH_INT;
				gga_take_digit(f, ch - CH_ZERO, 1'b0);
			end
			return;
		end
		if (ch == CH_DOT && frac_field && phase != PH_FRAC) begin
			phase = PH_FRAC;
			return;
		end
		phase = PH_DONE;
	endtask

	task automatic gga_model_char(logic [7:0] ch);
		bit hdr_ok;
		if (ch == CH_CR)
			return;
		if (ch == CH_LF) begin
			if (lin_len != 0)
				gga_close_line();
			return;
		end
		if (lin_len < HDR_LEN) begin
			case (lin_len)
				0:       hdr_ok = (ch == CH_DOLLAR);
				2:       hdr_ok = (ch == CH_P || ch == CH_N);
				5:       hdr_ok = (ch == CH_A);
				default: hdr_ok = (ch == CH_G);
			endcase
			if (!hdr_ok)
				hdr_good = 1'b0;
		end
		if (!star_seen) begin
			if (ch == CH_STAR) begin
				star_seen = 1'b1;
			end else if (ch == CH_COMMA) begin
				if (fld_num < FLD_MAX)
					fld_num++;
				phase = PH_LEAD;
			end else begin
				gga_scan(ch);
			end
		end
		lin_len++;
		// a full line ends on its own, last character included
		if (lin_len >= MAX_LINE - 1)
			gga_close_line();
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		if (err_cnt < MAX_PRINTED)
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
		err_cnt++;
	endtask

	// sender: one word per accepted character, payload held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
			rx_byte <= 8'h00;
		end else begin
			if (rx_valid && !rx_stall) begin
				gga_model_char(rx_byte);
				chars_taken++;
			end
			if (rx_valid && rx_stall) begin
				stalled_cycles++;
			end else if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				rx_valid <= 1'b1;
				rx_byte <= char_q.pop_front();
			end else begin
				rx_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_go)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// receiver: compare each accepted word with the oldest expected line result
	always @(posedge clk) begin
		gga_fix_t exp_r;
		if (arst_n && res_valid && !res_stall) begin
			if (fix_report_q.size() == 0) begin
				report_mismatch("unexpected result, parse_ok", parse_ok, 0);
			end else begin
				exp_r = fix_report_q.pop_front();
				reports_checked++;
				if (parse_ok !== exp_r.ok)
					report_mismatch("parse_ok", parse_ok, exp_r.ok);
				if (fix_valid !== exp_r.fix)
					report_mismatch("fix_valid", fix_valid, exp_r.fix);
				if (latitude !== exp_r.lat)
					report_mismatch("latitude", latitude, exp_r.lat);
				if (longitude !== exp_r.lon)
					report_mismatch("longitude", longitude, exp_r.lon);
				if (satellites !== exp_r.sat)
					report_mismatch("satellites", satellites, exp_r.sat);
				if (hdop_centi !== exp_r.hdop)
					report_mismatch("hdop_centi", hdop_centi, exp_r.hdop);
			end
		end
		res_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_cnt, fix_report_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic put_ch(logic [7:0] ch);
		char_q.push_back(ch);
		chars_queued++;
	endtask

	task automatic put_str(string s);
		for (int i = 0; i < s.len(); i++)
			put_ch(s[i]);
	endtask

	task automatic put_line(string s, bit with_cr);
		put_str(s);
		if (with_cr)
			put_ch(CH_CR);
		put_ch(CH_LF);
		lines_queued++;
	endtask

	task automatic put_digits(int n);
		repeat (n) put_ch(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic put_value(int ilen, int flen);
		case ($urandom_range(15))
			0: ;	// empty field
			1: begin
				case ($urandom_range(3))
					0: put_ch(CH_SPACE);
					1: put_ch(CH_TAB);
					2: put_ch(CH_VT);
					default: put_ch(CH_FF);
				endcase
				put_digits(ilen);
			end
			2: begin
				put_ch(CH_MINUS);
				put_digits(ilen);
			end
			3: begin
				put_ch(CH_PLUS);
				put_digits(ilen);
				put_ch(CH_DOT);
				put_digits(flen);
			end
			4: begin
				// an integer part of 10 to 15 digits, which can overflow the accumulators
				put_digits(10 + $urandom_range(5));
				put_ch(CH_DOT);
				put_digits(flen);
			end
			5: begin
				put_digits(ilen);
				put_ch(CH_DOT);
				put_digits(6 + $urandom_range(3));
			end
			6: begin
				put_digits(ilen);
				put_ch(8'($urandom_range(33, 126)));
				put_digits(2);
			end
			7: begin
				put_ch(CH_DOT);
				put_digits(1 + $urandom_range(3));
			end
			default: begin
				put_digits(ilen);
				if (flen > 0) begin
					put_ch(CH_DOT);
					put_digits(flen);
				end
			end
		endcase
	endtask

	task automatic put_hemi(logic [7:0] pos_ch, logic [7:0] neg_ch);
		case ($urandom_range(7))
			0: ;
			1: put_ch(8'($urandom_range(33, 126)));
			2: begin
				put_ch(neg_ch);
				put_ch(pos_ch);
			end
			3, 4: put_ch(neg_ch);
			default: put_ch(pos_ch);
		endcase
	endtask

	task automatic put_gga_line(bit pad);
		int last;
		int star_at;
		int bad_at;
		int k;
		logic [7:0] ch;
		string hex;
		hex = "0123456789ABCDEF";
		last = 14;
		k = $urandom_range(19);
		if (k < 3)
			last = $urandom_range(5, 9);
		else if (k == 3)
			last = $urandom_range(30, 40);
		star_at = ($urandom_range(9) == 0) ? $urandom_range(2, 10) : 99;
		bad_at = ($urandom_range(9) == 0) ? $urandom_range(5) : HDR_LEN;
		for (int i = 0; i < HDR_LEN; i++) begin
			case (i)
				0: ch = CH_DOLLAR;
				2: ch = $urandom_range(1) ? CH_P : CH_N;
				5: ch = CH_A;
				default: ch = CH_G;
			endcase
			if (i == bad_at)
				ch = 8'($urandom_range(33, 126));
			put_ch(ch);
		end
		for (int f = 1; f <= last; f++) begin
			put_ch((f == star_at) ? CH_STAR : CH_COMMA);
			case (f)
				1: begin
					put_digits(6);
					put_ch(CH_DOT);
					put_digits(2);
				end
				FLD_LAT: put_value($urandom_range(3, 5), $urandom_range(0, 6));
				FLD_LAT_HEMI: put_hemi(CH_N, CH_S);
				FLD_LON: put_value($urandom_range(4, 6), $urandom_range(0, 6));
				FLD_LON_HEMI: put_hemi("E", CH_W);
				FLD_FIX: put_value($urandom_range(1, 2), 0);
				FLD_SAT: put_value($urandom_range(1, 3), 0);
				FLD_HDOP: put_value($urandom_range(1, 3), $urandom_range(0, 3));
				9: begin
					put_value($urandom_range(1, 4), 1);
					// can run the line past its length limit
					if (pad)
						repeat ($urandom_range(60, 140)) put_ch(8'($urandom_range(32, 126)));
				end
				10, 12: put_str("M");
				default: if ($urandom_range(1)) put_digits($urandom_range(3));
			endcase
		end
		if (star_at > last) begin
			put_ch(CH_STAR);
			put_ch(hex[$urandom_range(15)]);
			put_ch(hex[$urandom_range(15)]);
		end
		if ($urandom_range(1))
			put_ch(CH_CR);
		put_ch(CH_LF);
		lines_queued++;
	endtask

	task automatic put_random_line();
		case ($urandom_range(19))
			0, 1: begin
				// raw noise over the whole byte range
				repeat ($urandom_range(1, 40)) put_ch(8'($urandom_range(255)));
				put_ch(CH_LF);
				lines_queued++;
			end
			2: put_gga_line(1'b1);
			3: begin
				put_ch(CH_CR);
				put_ch(CH_LF);
				put_gga_line(1'b0);
			end
			default: put_gga_line(1'b0);
		endcase
	endtask

	// sampled on the falling edge, away from the driving edge
	task automatic wait_drained();
		do @(negedge clk);
		while (char_q.size() != 0 || rx_valid || fix_report_q.size() != 0);
	endtask

	task automatic run_random_phase(int send_pct, int recv_pct, int n_lines);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n_lines) put_random_line();
		wait_drained();
	endtask

	initial begin
		gga_clear();
		send_idle_pct = 6;
		recv_idle_pct = 69;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed lines
		put_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47", 1'b1);
		put_line("$GNGGA,,,,,,,,,", 1'b0);
		put_line("$GNGGA,,,,,,,,", 1'b0);
		put_line("$GPGGA,0,9000.00000,S,18000.00000,W,-1,300,655.36,x,,,,", 1'b1);
		put_line("$GPGGA,0, +4807.1234567,N, -01131.5,E, 7,-3,-1.5,,,", 1'b0);
		put_line("$GNGGA,0,99999999999,S,.5,W,99999,\t12,1.999,,", 1'b0);
		put_line("$GPGGA,0,1234.5,,1234.5,X,1,2.5,.5*,,,,,,,,", 1'b0);
		put_line("$GPGGA,0,0000.0000,N,-0,W,0,0,0,,", 1'b0);
		put_line("$GPGGA", 1'b0);
		put_line("$GPRMC,1,2,3,4,5,6,7,8,9,10", 1'b0);
		put_line("", 1'b0);
		put_ch(CH_CR);
		put_ch(CH_CR);
		put_line("$GNGGA,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,,", 1'b0);
		// nul, all-ones, vertical tab and form feed inside one line
		put_str("$GPGGA,");
		put_ch(8'h00);
		put_ch(8'hFF);
		put_str(",1.2.3,N,+-5,E,");
		put_ch(CH_VT);
		put_ch(CH_FF);
		put_line("1a,,,,", 1'b0);
		// one line one short of the limit, then one forced to end at it
		put_str("$GNGGA,,,,,,,,,");
		repeat (MAX_LINE - 17) put_ch(CH_A);
		put_line("", 1'b0);
		put_str("$GNGGA,,,,,,,,,");
		repeat (MAX_LINE - 16) put_ch(CH_A);
		put_line("", 1'b0);
		wait_drained();

		run_random_phase(6, 69, 14);
		run_random_phase(69, 6, 14);
		run_random_phase(0, 0, 14);

		// hold the receiver off while short lines keep coming
		for (int i = 0; i < 24; i++) begin
			put_str("$GPGGA,");
			put_digits($urandom_range(1, 6));
			put_line(",,,,,,,,", 1'b0);
		end
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		wait_drained();

		repeat (20) @(posedge clk);
		$display("%0d characters over %0d lines, %0d line results checked",
			chars_taken, lines_queued, reports_checked);
		$display("input stalled for %0d cycles under receiver back-pressure", stalled_cycles);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
